FILE: src/cvni_pkg.sv
// Package for the credit-based virtual-channel network interface.
// Types and constants shared by the top level and the testbench; no dependencies.
package cvni_pkg;
    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_RTR_CRED  = 3'd1;
    localparam logic [2:0] CMD_RTR_PKT   = 3'd2;
    localparam logic [2:0] CMD_TERM_CRED = 3'd3;
    localparam logic [2:0] CMD_TERM_PKT  = 3'd4;

    localparam logic [1:0] KIND_PKT  = 2'd0;
    localparam logic [1:0] KIND_CRED = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CHAN  = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    localparam logic [1:0] REG_CHANS     = 2'd0;
    localparam logic [1:0] REG_RTR_INIT  = 2'd1;
    localparam logic [1:0] REG_TERM_INIT = 2'd2;

    localparam int ENTRY_W = 24;

    typedef struct packed {
        logic        dest;
        logic [1:0]  kind;
        logic [2:0]  chan;
        logic [15:0] tag;
        logic [7:0]  len;
        logic [1:0]  err;
    } result_t;
endpackage

FILE: src/credit_vc_network_interface_top.sv
// Top level of the credit-based virtual-channel network interface.
// Uses cvni_pkg and two cvni_ram instances (terminal and router packet FIFOs).
//
// One item in, zero or more result transfers out, one item at a time. Credit and
// packet items pass through the idle, decode and done states, with an emit
// state before done when they produce an error report. A tick walks every
// active channel in turn (RAM read, read latency, evaluate), after the arbiter
// read and wait states when the arbiter grants a channel, and spends an emit
// state on each result transfer; an output stall holds the emit state.
// Each result waits in an output register; the input stall is high while an
// item is in progress. The last result of an item has last set. Results of a
// tick come in this order: arbiter grant (packet to the router, credit to the
// terminal), then every router packet that is forwarded with its credit back
// to the router, in channel order.
module credit_vc_network_interface_top
    import cvni_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int FIFO_DEPTH   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [2:0]  chan,
    input  logic [15:0] pkt_tag,
    input  logic [7:0]  pkt_len,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        dest,
    output logic [1:0]  kind,
    output logic [2:0]  out_chan,
    output logic [15:0] out_tag,
    output logic [7:0]  out_len,
    output logic [1:0]  err_code,
    output logic        last
);
    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int AW = CW + PW;
    localparam int DEPTH = 1 << AW;
    localparam int NW = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ARB_RD, S_ARB_WAIT,
        S_CH_RD, S_CH_WAIT, S_CH_EVAL, S_EMIT, S_DONE
    } state_t;

    state_t state_reg;

    // FIFO pointer step with wrap at FIFO_DEPTH
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (32'(p) == FIFO_DEPTH - 1) ? '0 : p + PW'(1);
    endfunction

    // configuration
    logic [3:0] chans_reg;

    // per-channel control state
    logic [31:0]   now_reg;
    logic [PW-1:0] thead_reg [NUM_CHANNELS];
    logic [PW-1:0] rhead_reg [NUM_CHANNELS];
    logic [NW-1:0] tcnt_reg  [NUM_CHANNELS];
    logic [NW-1:0] rcnt_reg  [NUM_CHANNELS];
    logic [31:0]   tarr_reg  [NUM_CHANNELS];
    logic [31:0]   rarr_reg  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] tdone_reg, rdone_reg, req_reg;
    logic [7:0]    rcred_reg [NUM_CHANNELS];
    logic [7:0]    tcred_reg [NUM_CHANNELS];
    logic [CW-1:0] grant_reg;

    // latched item
    logic [2:0]  cmd_reg, chan_reg;
    logic [15:0] tag_reg;
    logic [7:0]  len_reg;

    // tick walk
    logic [CW-1:0]      ch_reg;
    logic [CW-1:0]      win_ch_reg;
    logic [ENTRY_W-1:0] rent_reg;      // router head entry of the walked channel
    result_t            stage_res_reg; // next result for the output register
    logic               stage_last_reg;
    logic               pend_reg;      // second result of a pair still to send
    result_t            pend_res_reg;
    logic               pend_last_reg;
    logic               after_arb_reg; // emission belongs to the arbiter step
    logic               more_reg;      // more channels to walk after this pair

    // output register
    result_t res_reg;
    logic    ovalid_reg, olast_reg;

    // active count clamped to 1..NUM_CHANNELS
    logic [3:0] act;
    always_comb
    begin
        act = chans_reg;
        if (act == 4'd0) act = 4'd1;
        if (32'(act) > NUM_CHANNELS) act = 4'(NUM_CHANNELS);
    end

    // RAM ports
    logic          t_we, r_we;
    logic [AW-1:0] t_waddr, r_waddr, t_raddr, r_raddr;
    logic [ENTRY_W-1:0] wentry, t_rdata, r_rdata;

    assign wentry = {tag_reg, len_reg};

    cvni_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_term_ram (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(wentry),
        .raddr(t_raddr), .rdata(t_rdata));

    cvni_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_rtr_ram (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(wentry),
        .raddr(r_raddr), .rdata(r_rdata));

    logic [CW-1:0] cch;
    assign cch = chan_reg[CW-1:0];
    logic chan_ok;
    assign chan_ok = {1'b0, chan_reg} < act;

    // write slot: head + count, wrapped
    logic [PW:0]   t_sum, r_sum;
    logic [PW-1:0] t_tail, r_tail;
    assign t_sum  = {1'b0, thead_reg[cch]} + (PW+1)'(tcnt_reg[cch]);
    assign r_sum  = {1'b0, rhead_reg[cch]} + (PW+1)'(rcnt_reg[cch]);
    assign t_tail = (32'(t_sum) >= FIFO_DEPTH) ? PW'(32'(t_sum) - FIFO_DEPTH) : t_sum[PW-1:0];
    assign r_tail = (32'(r_sum) >= FIFO_DEPTH) ? PW'(32'(r_sum) - FIFO_DEPTH) : r_sum[PW-1:0];

    assign t_we    = state_reg == S_DECODE && cmd_reg == CMD_TERM_PKT && chan_ok
                     && 32'(tcnt_reg[cch]) < FIFO_DEPTH;
    assign r_we    = state_reg == S_DECODE && cmd_reg == CMD_RTR_PKT && chan_ok
                     && 32'(rcnt_reg[cch]) < FIFO_DEPTH;
    assign t_waddr = {cch, t_tail};
    assign r_waddr = {cch, r_tail};

    logic [1:0] dec_err;
    assign dec_err = chan_ok ? ERR_FULL : ERR_CHAN;

    // arbiter: first requesting channel after last grant
    logic [NUM_CHANNELS-1:0] req_eff, req_next;
    logic          arb_hit;
    logic [CW-1:0] arb_ch;
    always_comb
    begin
        logic [CW-1:0] w;
        int            wsum;
        req_eff = req_reg;
        for (int i = 0; i < NUM_CHANNELS; i++)
            if (32'(i) < 32'(act) && tdone_reg[i] && rcred_reg[i] != 8'd0)
                req_eff[i] = 1'b1;
        arb_hit = 1'b0;
        arb_ch  = '0;
        for (int k = NUM_CHANNELS; k >= 1; k--)
        begin
            wsum = 32'(grant_reg) + k;
            if (wsum >= NUM_CHANNELS) wsum = wsum - NUM_CHANNELS;
            w = CW'(wsum);
            if (32'(w) < 32'(act) && req_eff[w])
            begin
                arb_hit = 1'b1;
                arb_ch  = w;
            end
        end
        req_next = req_eff;
        if (arb_hit) req_next[arb_ch] = 1'b0;
    end

    // router side reads the head, then the entry behind it
    assign t_raddr = (state_reg == S_ARB_RD) ? {win_ch_reg, thead_reg[win_ch_reg]}
                                              : {ch_reg, thead_reg[ch_reg]};
    assign r_raddr = (state_reg == S_CH_WAIT) ? {ch_reg, ptr_inc(rhead_reg[ch_reg])}
                                               : {ch_reg, rhead_reg[ch_reg]};

    // completion compares for the walked channel
    logic t_cmp, r_cmp_head, r_cmp_next;
    assign t_cmp      = ({1'b0, tarr_reg[ch_reg]} + 33'(t_rdata[7:0]) + 33'd1)
                        <= {1'b0, now_reg};
    assign r_cmp_head = ({1'b0, rarr_reg[ch_reg]} + 33'(rent_reg[7:0]) + 33'd1)
                        <= {1'b0, now_reg};
    assign r_cmp_next = ({1'b0, rarr_reg[ch_reg]} + 33'(r_rdata[7:0]) + 33'd1)
                        <= {1'b0, now_reg};

    logic ch_last;
    assign ch_last = 32'(ch_reg) + 1 >= 32'(act);

    logic fwd;   // router packet forwarded on walked channel
    assign fwd = rcnt_reg[ch_reg] != '0 && tcred_reg[ch_reg] != 8'd0 && rdone_reg[ch_reg];

    // router completion runs after forwarding, on the new head when one was popped
    logic rdone_next;
    assign rdone_next = fwd ? (rcnt_reg[ch_reg] != NW'(1) && r_cmp_next)
                            : (rdone_reg[ch_reg] || (rcnt_reg[ch_reg] != '0 && r_cmp_head));

    // any router forward on a channel after the walked one
    logic later_fwd;
    always_comb
    begin
        later_fwd = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
            if (32'(i) > 32'(ch_reg) && 32'(i) < 32'(act) && rcnt_reg[i] != '0
                && tcred_reg[i] != 8'd0 && rdone_reg[i])
                later_fwd = 1'b1;
    end

    // any router forward at all this tick; decides last for the arbiter credit
    logic arb_any_fwd;
    always_comb
    begin
        arb_any_fwd = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
            if (32'(i) < 32'(act) && rcnt_reg[i] != '0 && tcred_reg[i] != 8'd0
                && rdone_reg[i])
                arb_any_fwd = 1'b1;
    end

    logic in_acc, out_acc, load_out;
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = ovalid_reg && !out_stall;
    assign load_out = state_reg == S_EMIT && (!ovalid_reg || out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            chans_reg      <= 4'd2;
            now_reg        <= '0;
            tdone_reg      <= '0;
            rdone_reg      <= '0;
            req_reg        <= '0;
            grant_reg      <= '0;
            ovalid_reg     <= 1'b0;
            olast_reg      <= 1'b0;
            pend_reg       <= 1'b0;
            stage_last_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            after_arb_reg  <= 1'b0;
            more_reg       <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                thead_reg[i] <= '0;
                rhead_reg[i] <= '0;
                tcnt_reg[i]  <= '0;
                rcnt_reg[i]  <= '0;
                tarr_reg[i]  <= '0;
                rarr_reg[i]  <= '0;
                rcred_reg[i] <= 8'd4;
                tcred_reg[i] <= 8'd4;
            end
        end
        else
        begin
            if (load_out)
                ovalid_reg <= 1'b1;
            else if (out_acc)
                ovalid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CHANS: chans_reg <= cfg_data[3:0];
                    REG_RTR_INIT:
                        for (int i = 0; i < NUM_CHANNELS; i++) rcred_reg[i] <= cfg_data;
                    REG_TERM_INIT:
                        for (int i = 0; i < NUM_CHANNELS; i++) tcred_reg[i] <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                    if (in_acc)
                    begin
                        cmd_reg   <= cmd;
                        chan_reg  <= chan;
                        tag_reg   <= pkt_tag;
                        len_reg   <= pkt_len;
                        state_reg <= S_DECODE;
                    end
                S_DECODE:
                begin
                    stage_res_reg <= '{dest: (cmd_reg == CMD_TERM_CRED || cmd_reg == CMD_TERM_PKT),
                                       kind: KIND_ERR, chan: chan_reg, tag: '0, len: '0,
                                       err: dec_err};
                    stage_last_reg <= 1'b1;
                    pend_reg       <= 1'b0;
                    after_arb_reg  <= 1'b0;
                    more_reg       <= 1'b0;
                    case (cmd_reg)
                        CMD_TICK:
                        begin
                            req_reg <= req_next;
                            ch_reg  <= '0;
                            if (arb_hit)
                            begin
                                grant_reg  <= arb_ch;
                                win_ch_reg <= arb_ch;
                                state_reg  <= S_ARB_RD;
                            end
                            else
                                state_reg <= S_CH_RD;
                        end
                        CMD_RTR_CRED, CMD_TERM_CRED:
                            if (!chan_ok)
                                state_reg <= S_EMIT;
                            else
                            begin
                                state_reg <= S_DONE;
                                if (cmd_reg == CMD_RTR_CRED)
                                begin
                                    if (rcred_reg[cch] != 8'hFF)
                                        rcred_reg[cch] <= rcred_reg[cch] + 8'd1;
                                end
                                else if (tcred_reg[cch] != 8'hFF)
                                    tcred_reg[cch] <= tcred_reg[cch] + 8'd1;
                            end
                        CMD_RTR_PKT:
                            if (r_we)
                            begin
                                rcnt_reg[cch] <= rcnt_reg[cch] + NW'(1);
                                rarr_reg[cch] <= now_reg;
                                state_reg     <= S_DONE;
                            end
                            else
                                state_reg <= S_EMIT;
                        CMD_TERM_PKT:
                            if (t_we)
                            begin
                                tcnt_reg[cch] <= tcnt_reg[cch] + NW'(1);
                                tarr_reg[cch] <= now_reg;
                                state_reg     <= S_DONE;
                            end
                            else
                                state_reg <= S_EMIT;
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_ARB_RD:
                    state_reg <= S_ARB_WAIT;
                S_ARB_WAIT:
                begin
                    if (tcnt_reg[win_ch_reg] != '0)
                    begin
                        stage_res_reg <= '{dest: 1'b0, kind: KIND_PKT, chan: 3'(win_ch_reg),
                                           tag: t_rdata[23:8], len: t_rdata[7:0],
                                           err: ERR_NONE};
                        stage_last_reg <= 1'b0;
                        pend_res_reg <= '{dest: 1'b1, kind: KIND_CRED, chan: 3'(win_ch_reg),
                                          tag: '0, len: '0, err: ERR_NONE};
                        pend_last_reg <= !arb_any_fwd;
                        pend_reg      <= 1'b1;
                        thead_reg[win_ch_reg] <= ptr_inc(thead_reg[win_ch_reg]);
                        tcnt_reg[win_ch_reg]  <= tcnt_reg[win_ch_reg] - NW'(1);
                        if (rcred_reg[win_ch_reg] != 8'd0)
                            rcred_reg[win_ch_reg] <= rcred_reg[win_ch_reg] - 8'd1;
                        tdone_reg[win_ch_reg] <= 1'b0;
                        after_arb_reg <= 1'b1;
                        state_reg     <= S_EMIT;
                    end
                    else
                        state_reg <= S_CH_RD;
                end
                S_CH_RD:
                    state_reg <= S_CH_WAIT;
                S_CH_WAIT:
                begin
                    rent_reg  <= r_rdata;
                    state_reg <= S_CH_EVAL;
                end
                S_CH_EVAL:
                begin
                    // terminal completion
                    if (tcnt_reg[ch_reg] != '0 && !tdone_reg[ch_reg] && t_cmp)
                        tdone_reg[ch_reg] <= 1'b1;
                    rdone_reg[ch_reg] <= rdone_next;
                    after_arb_reg <= 1'b0;
                    if (fwd)
                    begin
                        tcred_reg[ch_reg] <= tcred_reg[ch_reg] - 8'd1;
                        rhead_reg[ch_reg] <= ptr_inc(rhead_reg[ch_reg]);
                        rcnt_reg[ch_reg]  <= rcnt_reg[ch_reg] - NW'(1);
                        stage_res_reg <= '{dest: 1'b1, kind: KIND_PKT, chan: 3'(ch_reg),
                                           tag: rent_reg[23:8], len: rent_reg[7:0],
                                           err: ERR_NONE};
                        stage_last_reg <= 1'b0;
                        pend_res_reg <= '{dest: 1'b0, kind: KIND_CRED, chan: 3'(ch_reg),
                                          tag: '0, len: '0, err: ERR_NONE};
                        pend_last_reg <= !later_fwd;
                        pend_reg      <= 1'b1;
                        more_reg      <= !ch_last;
                        state_reg     <= S_EMIT;
                    end
                    else if (!ch_last)
                    begin
                        ch_reg    <= ch_reg + CW'(1);
                        state_reg <= S_CH_RD;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_EMIT:
                    if (load_out)
                    begin
                        res_reg   <= stage_res_reg;
                        olast_reg <= stage_last_reg;
                        if (pend_reg)
                        begin
                            stage_res_reg  <= pend_res_reg;
                            stage_last_reg <= pend_last_reg;
                            pend_reg       <= 1'b0;
                        end
                        else if (cmd_reg != CMD_TICK)
                            state_reg <= S_DONE;
                        else if (after_arb_reg)
                            state_reg <= S_CH_RD;
                        else if (more_reg)
                        begin
                            ch_reg    <= ch_reg + CW'(1);
                            state_reg <= S_CH_RD;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                S_DONE:
                    if (!ovalid_reg || out_acc)
                    begin
                        state_reg <= S_IDLE;
                        if (cmd_reg == CMD_TICK) now_reg <= now_reg + 32'd1;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = ovalid_reg;
    assign dest      = res_reg.dest;
    assign kind      = res_reg.kind;
    assign out_chan  = res_reg.chan;
    assign out_tag   = res_reg.tag;
    assign out_len   = res_reg.len;
    assign err_code  = res_reg.err;
    assign last      = olast_reg;

    // no item is taken while a previous one is in progress
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input accepted while busy");
    // an error report always carries a nonzero code
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_ERR) |-> (err_code != ERR_NONE))
        else $error("error report without code");
    // a forwarded packet carries no error code and is never the last result
    a_pkt_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_PKT) |-> (err_code == ERR_NONE && !last))
        else $error("packet result malformed");
endmodule

FILE: src/cvni_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module cvni_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: dv/cvni_checker.sv
// Scoreboard for the credit-based VC network interface: watches the config port and both
// transfer channels, predicts the results of every accepted item and compares them in order.
// Depends on cvni_pkg only.
module cvni_checker
    import cvni_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [2:0]  chan,
    input  logic [15:0] pkt_tag,
    input  logic [7:0]  pkt_len,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        dest,
    input  logic [1:0]  kind,
    input  logic [2:0]  out_chan,
    input  logic [15:0] out_tag,
    input  logic [7:0]  out_len,
    input  logic [1:0]  err_code,
    input  logic        last,
    output int          fails,
    output int          outstanding,
    output int          pkts_moved,
    output int          errs_seen
);
    localparam int NCH   = 8;
    localparam int DEPTH = 8;

    typedef struct packed {
        result_t r;
        logic    last;
    } beat_t;

    beat_t       expected_q[$];

    logic [3:0]  chans_reg;
    logic [7:0]  rtr_init, term_init;
    logic [31:0] tick_now;
    logic [23:0] term_q [NCH][DEPTH];
    logic [23:0] rtr_q  [NCH][DEPTH];
    int          term_hd[NCH], rtr_hd[NCH], term_cnt[NCH], rtr_cnt[NCH];
    logic [31:0] term_arr[NCH], rtr_arr[NCH];
    bit          term_rdy[NCH], rtr_rdy[NCH];
    logic [7:0]  rtr_cred[NCH], term_cred[NCH];
    logic [7:0]  grant_req;
    int          grant_last;

    function automatic int active_chans();
        int n;
        n = chans_reg;
        if (n < 1) n = 1;
        if (n > NCH) n = NCH;
        return n;
    endfunction

    task automatic push_result(input logic d, input logic [1:0] k, input int ch,
                               input logic [15:0] tg, input logic [7:0] ln,
                               input logic [1:0] e);
        beat_t b;
        b.r.dest = d;
        b.r.kind = k;
        b.r.chan = ch[2:0];
        b.r.tag  = tg;
        b.r.len  = ln;
        b.r.err  = e;
        b.last   = 1'b0;
        expected_q.insert(expected_q.size(), b);
    endtask

    function automatic bit head_due(input logic [23:0] ent, input logic [31:0] arr);
        longint due;
        due = longint'(arr) + longint'(ent[7:0]) + 1;
        return due <= longint'(tick_now);
    endfunction

    task automatic do_tick();
        int act, w;
        logic [23:0] ent;
        act = active_chans();
        for (int i = 0; i < act; i++)
            if (term_rdy[i] && rtr_cred[i] != 0) grant_req[i] = 1'b1;
        for (int k = 1; k <= NCH; k++) begin
            w = (grant_last + k) % NCH;
            if (w < act && grant_req[w]) begin
                grant_last   = w;
                grant_req[w] = 1'b0;
                if (term_cnt[w] != 0) begin
                    ent         = term_q[w][term_hd[w]];
                    term_hd[w]  = (term_hd[w] + 1) % DEPTH;
                    term_cnt[w]--;
                    push_result(1'b0, KIND_PKT, w, ent[23:8], ent[7:0], ERR_NONE);
                    if (rtr_cred[w] != 0) rtr_cred[w]--;
                    term_rdy[w] = 0;
                    push_result(1'b1, KIND_CRED, w, '0, '0, ERR_NONE);
                end
                break;
            end
        end
        for (int i = 0; i < act; i++)
            if (term_cnt[i] != 0 && !term_rdy[i] && head_due(term_q[i][term_hd[i]], term_arr[i]))
                term_rdy[i] = 1;
        for (int i = 0; i < act; i++)
            if (rtr_cnt[i] != 0 && term_cred[i] != 0 && rtr_rdy[i]) begin
                term_cred[i]--;
                rtr_rdy[i] = 0;
                ent        = rtr_q[i][rtr_hd[i]];
                rtr_hd[i]  = (rtr_hd[i] + 1) % DEPTH;
                rtr_cnt[i]--;
                push_result(1'b1, KIND_PKT, i, ent[23:8], ent[7:0], ERR_NONE);
                push_result(1'b0, KIND_CRED, i, '0, '0, ERR_NONE);
            end
        for (int i = 0; i < act; i++)
            if (rtr_cnt[i] != 0 && head_due(rtr_q[i][rtr_hd[i]], rtr_arr[i]))
                rtr_rdy[i] = 1;
        tick_now++;
    endtask

    task automatic predict_item(input logic [2:0] c, input logic [2:0] ch,
                                input logic [15:0] tg, input logic [7:0] ln);
        int  n_prior;
        int  i;
        bit  side;
        beat_t b;
        n_prior = expected_q.size();
        i       = ch;
        side    = (c == CMD_TERM_CRED || c == CMD_TERM_PKT);
        case (c)
            CMD_TICK: do_tick();
            CMD_RTR_CRED, CMD_TERM_CRED: begin
                if (i >= active_chans())
                    push_result(side, KIND_ERR, i, '0, '0, ERR_CHAN);
                else if (side && term_cred[i] != 8'hff)
                    term_cred[i]++;
                else if (!side && rtr_cred[i] != 8'hff)
                    rtr_cred[i]++;
            end
            CMD_RTR_PKT, CMD_TERM_PKT: begin
                if (i >= active_chans())
                    push_result(side, KIND_ERR, i, '0, '0, ERR_CHAN);
                else if ((side ? term_cnt[i] : rtr_cnt[i]) >= DEPTH)
                    push_result(side, KIND_ERR, i, '0, '0, ERR_FULL);
                else if (side) begin
                    term_q[i][(term_hd[i] + term_cnt[i]) % DEPTH] = {tg, ln};
                    term_cnt[i]++;
                    term_arr[i] = tick_now;
                end else begin
                    rtr_q[i][(rtr_hd[i] + rtr_cnt[i]) % DEPTH] = {tg, ln};
                    rtr_cnt[i]++;
                    rtr_arr[i] = tick_now;
                end
            end
            default: ;
        endcase
        if (expected_q.size() > n_prior) begin
            b      = expected_q[$];
            b.last = 1'b1;
            expected_q[$] = b;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        beat_t got, exp_b;
        if (!rst_n) begin
            chans_reg  = 4'd2;
            rtr_init   = 8'd4;
            term_init  = 8'd4;
            tick_now   = '0;
            grant_req  = '0;
            grant_last = 0;
            for (int i = 0; i < NCH; i++) begin
                term_hd[i] = 0; rtr_hd[i] = 0; term_cnt[i] = 0; rtr_cnt[i] = 0;
                term_arr[i] = '0; rtr_arr[i] = '0; term_rdy[i] = 0; rtr_rdy[i] = 0;
                rtr_cred[i] = 8'd4; term_cred[i] = 8'd4;
            end
            expected_q.delete();
            fails      = 0;
            pkts_moved = 0;
            errs_seen  = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CHANS: chans_reg = cfg_data[3:0];
                    REG_RTR_INIT: begin
                        rtr_init = cfg_data;
                        for (int i = 0; i < NCH; i++) rtr_cred[i] = cfg_data;
                    end
                    REG_TERM_INIT: begin
                        term_init = cfg_data;
                        for (int i = 0; i < NCH; i++) term_cred[i] = cfg_data;
                    end
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) predict_item(cmd, chan, pkt_tag, pkt_len);
            if (out_valid && !out_stall) begin
                got.r    = '{dest, kind, out_chan, out_tag, out_len, err_code};
                got.last = last;
                if (got.r.kind == KIND_PKT) pkts_moved++;
                if (got.r.kind == KIND_ERR) errs_seen++;
                if (expected_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result %p", $time, got);
                end else begin
                    exp_b = expected_q.pop_front();
                    if (exp_b !== got) begin
                        fails++;
                        $display("%0t: mismatch expected %p actual %p", $time, exp_b, got);
                    end
                end
            end
        end
        outstanding = expected_q.size();
    end
endmodule

FILE: dv/tb.sv
// Testbench top for credit_vc_network_interface_top: clock, reset, config phases,
// directed and random item stimulus, output backpressure and the verdict.
// Depends on cvni_pkg, the DUT and cvni_checker.
module tb;
    import cvni_pkg::*;

    localparam int LIMIT     = 400000;  // cycles; many times the slowest legal run
    localparam int DRAIN     = 100;     // covers a full tick walk plus results
    localparam int NPHASE    = 6;
    localparam int PER_PHASE = 50;

    logic        clk, rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid, in_stall;
    logic [2:0]  cmd, chan;
    logic [15:0] pkt_tag;
    logic [7:0]  pkt_len;
    logic        out_valid, out_stall;
    logic        dest, last;
    logic [1:0]  kind, err_code;
    logic [2:0]  out_chan;
    logic [15:0] out_tag;
    logic [7:0]  out_len;

    int fails, outstanding, pkts_moved, errs_seen;
    int cyc;
    int n_active;       // active channel count as the stimulus sees it
    bit calm;           // no idling on either side while set
    bit hold_go;        // asks the receiver for one long hold-off
    int items_sent;

    credit_vc_network_interface_top dut (.*);

    cvni_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Cycle limit: this process only ever ends the run on a hang.
    initial
    begin
        cyc = 0;
        while (cyc < LIMIT)
        begin
            @(posedge clk);
            cyc++;
        end
        $display("timeout after %0d cycles, %0d results still expected", cyc, outstanding);
        $display("tb: FAIL");
        $finish;
    end

    // Receiver side: random stall, one long hold-off on request, none while calm.
    initial
    begin
        bit held;
        held = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !held)
            begin
                held = 1;
                // Block keeps one item in flight; the sender keeps offering,
                // so in_stall stays up once a result waits in the output register.
                for (int k = 0; k < 300; k++)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            out_stall <= !calm && ($urandom_range(99) < 33);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // One transfer on the input channel. Payload holds until accepted.
    task automatic send(input logic [2:0] c, input logic [2:0] ch,
                        input logic [15:0] tg, input logic [7:0] ln);
        while (!calm && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        chan     <= ch;
        pkt_tag  <= tg;
        pkt_len  <= ln;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    // Idle point: everything delivered, then room for a result-free tick to finish.
    task automatic quiesce();
        in_valid <= 1'b0;
        @(negedge clk);
        wait (outstanding == 0);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic random_item();
        int          r;
        logic [2:0]  c, ch;
        logic [7:0]  ln;
        r  = $urandom_range(99);
        ch = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(n_active - 1));
        case ($urandom_range(19))
            0:       ln = 8'($urandom_range(255));
            1, 2, 3: ln = 8'($urandom_range(20));
            default: ln = 8'($urandom_range(3));
        endcase
        if (r < 40)      c = CMD_TICK;
        else if (r < 60) c = CMD_TERM_PKT;
        else if (r < 78) c = CMD_RTR_PKT;
        else if (r < 87) c = CMD_TERM_CRED;
        else if (r < 96) c = CMD_RTR_CRED;
        else             c = 3'($urandom_range(5, 7));   // undefined commands
        send(c, ch, 16'($urandom), ln);
    endtask

    initial
    begin
        // Config settings per phase: extremes of channel count (0 and 15 clamp)
        // and of both credit loads.
        logic [3:0] ph_chans [NPHASE] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd2};
        logic [7:0] ph_rtr   [NPHASE] = '{8'd255, 8'd0, 8'd1, 8'd200, 8'd2, 8'd4};
        logic [7:0] ph_term  [NPHASE] = '{8'd255, 8'd0, 8'd7, 8'd255, 8'd1, 8'd4};
        int c_eff;

        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; cmd = CMD_TICK; chan = '0; pkt_tag = '0; pkt_len = '0;
        calm = 0; hold_go = 0; items_sent = 0; n_active = 2;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, reset config (2 channels, 4 credits each way).
        send(CMD_TERM_PKT, 3'd0, 16'hffff, 8'd0);
        send(CMD_RTR_PKT, 3'd0, 16'h0000, 8'd1);
        send(CMD_RTR_PKT, 3'd1, 16'h5a5a, 8'd255);      // longest length
        for (int k = 0; k < 4; k++) send(CMD_TICK, 3'd0, 16'h0, 8'h0);
        send(CMD_TERM_PKT, 3'd7, 16'h1234, 8'd2);       // channel out of range
        send(CMD_RTR_CRED, 3'd2, 16'h0, 8'h0);          // credit out of range
        send(CMD_TERM_CRED, 3'd0, 16'h0, 8'h0);
        send(3'd5, 3'd0, 16'h0, 8'h0);                  // unknown commands
        send(3'd7, 3'd7, 16'hffff, 8'hff);
        for (int k = 0; k < 9; k++)                     // ninth one overflows
            send(CMD_TERM_PKT, 3'd1, 16'(16'h8000 + k), 8'h0);
        for (int k = 0; k < 3; k++) send(CMD_TICK, 3'd0, 16'h0, 8'h0);

        for (int p = 0; p < NPHASE; p++)
        begin
            quiesce();
            write_reg(REG_CHANS, 8'(ph_chans[p]));
            write_reg(REG_RTR_INIT, ph_rtr[p]);
            write_reg(REG_TERM_INIT, ph_term[p]);
            c_eff = ph_chans[p];
            n_active = (c_eff < 1) ? 1 : (c_eff > 8) ? 8 : c_eff;
            calm = (p == 4);
            // Saturated credits: credit events must not wrap.
            if (ph_rtr[p] == 8'd255)
            begin
                send(CMD_RTR_CRED, 3'd0, 16'h0, 8'h0);
                send(CMD_TERM_CRED, 3'(n_active - 1), 16'h0, 8'h0);
            end
            for (int k = 0; k < PER_PHASE; k++)
            begin
                if (p == 1 && k == 20) hold_go = 1;
                if (p == 3 && k == 30)
                begin
                    // Sender pause until the block has delivered everything.
                    in_valid <= 1'b0;
                    @(negedge clk);
                    wait (outstanding == 0);
                    @(negedge clk);
                end
                random_item();
            end
            // Flush with ticks so packets complete and drain.
            for (int k = 0; k < 12; k++) send(CMD_TICK, 3'd0, 16'h0, 8'h0);
        end

        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN) @(posedge clk);
        if (outstanding != 0) $display("%0d results never arrived", outstanding);

        $display("%0d items over %0d config phases; %0d packets forwarded, %0d error reports",
                 items_sent, NPHASE + 1, pkts_moved, errs_seen);
        if (fails == 0 && outstanding == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

FILE: files.f
src/cvni_pkg.sv
src/cvni_ram.sv
src/credit_vc_network_interface_top.sv
dv/cvni_checker.sv
dv/tb.sv
